### hdl/spiadc_pkg.sv
// spiadc_pkg: shared types and constants of the spi register adc scanner
// stand-alone, no dependencies; used by hdl/spi_register_adc_scanner.sv
package spiadc_pkg;

  // fixed field widths of one input beat and one result beat
  localparam int KIND_W      = 2;
  localparam int RX_W        = 8;
  localparam int SMP_W       = 10;
  localparam int CHAN_W      = 3;
  localparam int IN_TDATA_W  = 24;  // select_level, rx_byte, sample, zero pad
  localparam int OUT_TDATA_W = 16;  // tx_byte, start_conv, conv_channel, attention, pad

  // register map
  localparam logic [RX_W-1:0] ADDR_MASK_REG    = 8'h01;
  localparam logic [RX_W-1:0] ADDR_SAMPLE_BASE = 8'h10;
  localparam logic [RX_W-1:0] ADDR_SAMPLE_END  = 8'h18;
  localparam logic [15:0]     HIGH_BYTE_MASK   = 16'hFF00;

  // event kind carried in tuser
  typedef enum logic [KIND_W-1:0] {
    KIND_SELECT    = 2'd0,
    KIND_BYTE      = 2'd1,
    KIND_CONV_DONE = 2'd2
  } kind_e;

endpackage

### hdl/spi_register_adc_scanner.sv
// spi_register_adc_scanner: register-mapped spi slave in front of a round-robin adc scanner
// depends on hdl/spiadc_pkg.sv
//
// usage
//   slave side: one beat per event. tuser is the event kind (select edge, spi byte
//   received, conversion finished; the unused code only runs the idle-start check).
//   tdata carries select_level, rx_byte and sample.
//   master side: exactly one result beat per input beat, in order: tx_byte to load
//   into the spi shifter, start_conv with conv_channel, and the attention level.
// pipeline
//   a beat lands in the input register at its accept edge and is processed from there
//   into the result register once that register is free or being drained.
//   one beat per cycle sustained while m_axis_tready stays high; the event step is a byte decode, a 10-bit store
//   access and an 8-wide wrap-around priority search, all combinational.
// reset
//   rst_ni clears link, frame, mask, scanner and the whole sample store at once
//   (store is in flops, no clearing pass); both registers come up empty.
// stall
//   when m_axis_tready is low the result holds and one more beat waits in the input
//   register; s_axis_tready drops only once both are full.
module spi_register_adc_scanner #(
  parameter int CHANNELS    = 8,   // 1..8 scanned adc channels
  parameter int SAMPLE_BITS = 10   // 8..16 stored sample width
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // [0] select_level, [8:1] rx_byte, [18:9] sample, [23:19] zero
  input  logic [spiadc_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // [1:0] kind
  input  logic [spiadc_pkg::KIND_W-1:0]      s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [7:0] tx_byte, [8] start_conv, [11:9] conv_channel, [12] attention, [15:13] zero
  output logic [spiadc_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
  import spiadc_pkg::*;

  localparam int IDX_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int FROM_W = CHAN_W + 1;

  // position inside the three-byte frame
  typedef enum logic [1:0] {
    PH_ADDR = 2'd0,
    PH_DATA = 2'd1,
    PH_TAIL = 2'd2
  } phase_e;

  // first enabled channel at or after from, wrapping; the last hit of the
  // downward scan is the lowest one
  function automatic logic [CHAN_W-1:0] next_chan(input logic [CHANNELS-1:0] m,
                                                  input logic [FROM_W-1:0]   from);
    logic              found_hi;
    logic [CHAN_W-1:0] hi;
    logic [CHAN_W-1:0] lo;
    found_hi = 1'b0;
    hi       = '0;
    lo       = '0;
    for (int c = CHANNELS - 1; c >= 0; c--) begin
      if (m[c]) begin
        lo = CHAN_W'(c);
        if (FROM_W'(c) >= from) begin
          hi       = CHAN_W'(c);
          found_hi = 1'b1;
        end
      end
    end
    return found_hi ? hi : lo;
  endfunction

  // input register
  logic                  in_valid_q;
  logic [IN_TDATA_W-1:0] in_data_q;
  logic [KIND_W-1:0]     in_kind_q;

  // result register
  logic                   out_valid_q;
  logic [OUT_TDATA_W-1:0] out_data_q;
  logic [OUT_TDATA_W-1:0] out_data_d;

  // block state
  logic                   link_q, link_d;
  phase_e                 phase_q, phase_d;
  logic [RX_W-1:0]        addr_q, addr_d;
  logic [RX_W-1:0]        pend_q, pend_d;
  logic [RX_W-1:0]        shift_q, shift_d;
  logic                   attn_q, attn_d;
  logic [CHANNELS-1:0]    mask_q, mask_d;
  logic                   act_v_q, act_v_d;
  logic [CHAN_W-1:0]      act_q, act_d;
  logic [SAMPLE_BITS-1:0] store_q [CHANNELS];

  logic                   advance;
  kind_e                  kind_in;
  logic                   sel_in;
  logic [RX_W-1:0]        rx_in;
  logic [SMP_W-1:0]       smp_in;
  logic [RX_W-1:0]        rd_off;
  logic                   rd_hit;
  logic [15:0]            rd_v16;
  logic [15:0]            rd_hi16;
  logic                   wr_en;
  logic                   start;
  logic [CHAN_W-1:0]      chan;
  logic [FROM_W-1:0]      from;

  // process the held beat when the result register is free or being drained
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  assign kind_in = kind_e'(in_kind_q);
  assign sel_in  = in_data_q[0];
  assign rx_in   = in_data_q[8:1];
  assign smp_in  = in_data_q[18:9];

  // sample register read for an address byte
  assign rd_off = rx_in - ADDR_SAMPLE_BASE;
  assign rd_hit = (rx_in >= ADDR_SAMPLE_BASE) && (rx_in < ADDR_SAMPLE_END) &&
                  (rd_off < RX_W'(CHANNELS));

  always_comb begin
    rd_v16 = '0;
    rd_v16[SAMPLE_BITS-1:0] = store_q[rd_off[IDX_W-1:0]];
    rd_hi16 = rd_v16 & HIGH_BYTE_MASK;
  end

  always_comb begin
    link_d  = link_q;
    phase_d = phase_q;
    addr_d  = addr_q;
    pend_d  = pend_q;
    shift_d = shift_q;
    attn_d  = attn_q;
    mask_d  = mask_q;
    act_v_d = act_v_q;
    act_d   = act_q;
    wr_en   = 1'b0;
    start   = 1'b0;
    chan    = '0;
    from    = '0;

    case (kind_in)
      KIND_SELECT: begin
        // asserted select (low) enables the link; either edge restarts the frame
        link_d  = !sel_in;
        attn_d  = !sel_in;
        phase_d = PH_ADDR;
      end
      KIND_BYTE: begin
        if (link_q) begin
          unique case (phase_q)
            PH_ADDR: begin
              addr_d = rx_in;
              if (rd_hit) begin
                shift_d = rd_v16[7:0];
                pend_d  = rd_hi16[15:8];
              end else begin
                shift_d = '0;
                pend_d  = '0;
              end
              phase_d = PH_DATA;
            end
            PH_DATA: begin
              if (addr_q == ADDR_MASK_REG) begin
                mask_d = rx_in[CHANNELS-1:0];
              end
              shift_d = pend_q;
              phase_d = PH_TAIL;
            end
            default: begin
              shift_d = '0;
              phase_d = PH_ADDR;
            end
          endcase
        end
      end
      KIND_CONV_DONE: begin
        // store for the active channel, then move on round-robin
        if (act_v_q) begin
          wr_en = 1'b1;
          from  = FROM_W'(act_q) + FROM_W'(1);
        end
        if (mask_q == '0) begin
          act_v_d = 1'b0;
        end else begin
          act_d   = next_chan(mask_q, from);
          act_v_d = 1'b1;
          start   = 1'b1;
          chan    = act_d;
        end
      end
      default: ;
    endcase

    // idle scanner with channels enabled starts on the lowest one
    if (!act_v_d && (mask_d != '0)) begin
      act_d   = next_chan(mask_d, '0);
      act_v_d = 1'b1;
      start   = 1'b1;
      chan    = act_d;
    end

    out_data_d = {3'b000, attn_d, chan, start, shift_d};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      link_q      <= 1'b0;
      phase_q     <= PH_ADDR;
      addr_q      <= '0;
      pend_q      <= '0;
      shift_q     <= '0;
      attn_q      <= 1'b0;
      mask_q      <= '0;
      act_v_q     <= 1'b0;
      act_q       <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        store_q[i] <= '0;
      end
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end

      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end

      if (advance) begin
        link_q  <= link_d;
        phase_q <= phase_d;
        addr_q  <= addr_d;
        pend_q  <= pend_d;
        shift_q <= shift_d;
        attn_q  <= attn_d;
        mask_q  <= mask_d;
        act_v_q <= act_v_d;
        act_q   <= act_d;
        if (wr_en) begin
          store_q[act_q[IDX_W-1:0]] <= SAMPLE_BITS'(smp_in);
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_data_q <= s_axis_tdata;
      in_kind_q <= s_axis_tuser;
    end
    if (advance) begin
      out_data_q <= out_data_d;
    end
  end

`ifndef SYNTH
  // an idle scanner only ever coexists with an empty mask
  a_idle_means_no_mask: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !act_v_q |-> (mask_q == '0))
    else $error("scanner idle with channels enabled");

  // the active channel always exists
  a_active_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    act_v_q |-> ({1'b0, act_q} < FROM_W'(CHANNELS)))
    else $error("active channel beyond channel count");

  // a held beat is not lost or altered while the result side is blocked
  a_input_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !advance) |=> (in_valid_q && $stable(in_data_q) && $stable(in_kind_q)))
    else $error("waiting input beat dropped or changed");

  // every processed beat produces a result beat
  a_result_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("processed beat gave no result");
`endif

endmodule

### tb/spi_register_adc_scanner_tb.sv
// spi_register_adc_scanner_tb: self-checking testbench of the spi register adc scanner
// depends on hdl/spiadc_pkg.sv and hdl/spi_register_adc_scanner.sv
// directed frames and conversions first, then random frames, noise and broken frames
module spi_register_adc_scanner_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import spiadc_pkg::*;

  localparam int CHANNELS    = 8;
  localparam int SAMPLE_BITS = 10;
  localparam int RANDOM_EVENTS = 1550;
  localparam int TAIL_CYCLES   = 12;
  localparam realtime RUN_LIMIT = 5ms;

  // the one kind code with no event behind it
  localparam logic [KIND_W-1:0] KIND_NONE = 2'd3;
  localparam logic [RX_W-1:0]   ADDR_NONE = 8'h00;
  localparam logic [RX_W-1:0]   ADDR_TOP  = 8'hFF;

  typedef struct {
    logic [KIND_W-1:0] kind;
    logic              sel;
    logic [RX_W-1:0]   rx;
    logic [SMP_W-1:0]  smp;
    bit                drain;  // hold this beat until every result is back
  } spi_event_t;

  typedef struct {
    logic [7:0]        tx;
    logic              start;
    logic [CHAN_W-1:0] chan;
    logic              attn;
  } scan_out_t;

  logic clk_i;
  logic rst_ni = 1'b0;

  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic [KIND_W-1:0]      s_axis_tuser  = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  spi_register_adc_scanner #(
    .CHANNELS   (CHANNELS),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  spi_event_t event_q[$];         // stimulus not yet on the bus
  scan_out_t  expected_out_q[$];  // predicted result beats, oldest first
  int         fail_count = 0;
  int         event_total = 0;
  int         accepted_cnt = 0;

  // ---------------------------------------------------------------------------
  // predictor state, all zero out of reset
  // ---------------------------------------------------------------------------
  logic                   link_on   = 1'b0;
  logic [1:0]             phase     = 2'd0;
  logic [7:0]             addr_reg  = '0;
  logic [7:0]             high_pend = '0;
  logic [7:0]             shift_reg = '0;
  logic                   attn_reg  = 1'b0;
  logic [7:0]             mask_reg  = '0;
  logic                   scan_busy = 1'b0;
  logic [CHAN_W-1:0]      cur_chan  = '0;
  logic [SAMPLE_BITS-1:0] samples [8] = '{default: '0};

  // first enabled channel at or after from, wrapping around
  function automatic logic [CHAN_W-1:0] first_enabled(input int from);
    int c;
    for (int k = 0; k < CHANNELS; k++) begin
      c = (from + k) % CHANNELS;
      if (mask_reg[c]) return CHAN_W'(c);
    end
    return '0;
  endfunction

  // advances the predicted scanner by one accepted beat and queues its result
  task automatic predict_scanner_response(input spi_event_t ev);
    logic              start;
    logic [CHAN_W-1:0] chan;
    logic [15:0]       stored;
    int                from;
    start = 1'b0;
    chan  = '0;
    case (ev.kind)
      KIND_SELECT: begin
        link_on  = !ev.sel;
        attn_reg = !ev.sel;
        phase    = 2'd0;
      end
      KIND_BYTE: begin
        if (link_on) begin
          if (phase == 2'd0) begin
            // address byte, preload the low byte of a sample register
            addr_reg = ev.rx;
            if (ev.rx >= ADDR_SAMPLE_BASE && ev.rx < ADDR_SAMPLE_END &&
                int'(ev.rx - ADDR_SAMPLE_BASE) < CHANNELS) begin
              stored    = 16'(samples[3'(ev.rx - ADDR_SAMPLE_BASE)]);
              shift_reg = stored[7:0];
              high_pend = 8'((stored & HIGH_BYTE_MASK) >> 8);
            end else begin
              shift_reg = '0;
              high_pend = '0;
            end
            phase = 2'd1;
          end else if (phase == 2'd1) begin
            if (addr_reg == ADDR_MASK_REG) mask_reg = ev.rx & 8'((1 << CHANNELS) - 1);
            shift_reg = high_pend;
            phase     = 2'd2;
          end else begin
            shift_reg = '0;
            phase     = 2'd0;
          end
        end
      end
      KIND_CONV_DONE: begin
        from = 0;
        if (scan_busy) begin
          samples[cur_chan] = ev.smp;
          from = int'(cur_chan) + 1;
        end
        if (mask_reg == '0) begin
          scan_busy = 1'b0;
        end else begin
          cur_chan  = first_enabled(from);
          scan_busy = 1'b1;
          start     = 1'b1;
          chan      = cur_chan;
        end
      end
      default: ;
    endcase
    // idle scanner with something enabled starts on the lowest channel
    if (!scan_busy && mask_reg != '0) begin
      cur_chan  = first_enabled(0);
      scan_busy = 1'b1;
      start     = 1'b1;
      chan      = cur_chan;
    end
    expected_out_q.push_back('{tx: shift_reg, start: start, chan: chan, attn: attn_reg});
  endtask

  // gap before the next beat, with occasional stretches of back-to-back beats
  function automatic int draw_gap(inout int burst);
    if (burst > 0) begin
      burst--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) begin
      burst = $urandom_range(8, 40);
      return 0;
    end
    return $urandom_range(0, 13);
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus building
  // ---------------------------------------------------------------------------
  logic gen_selected = 1'b0;  // select level as the generator last left it

  task automatic add_event(input logic [KIND_W-1:0] kind, input logic sel,
                           input logic [RX_W-1:0] rx, input logic [SMP_W-1:0] smp,
                           input bit drain = 1'b0);
    spi_event_t ev;
    ev.kind  = kind;
    ev.sel   = sel;
    ev.rx    = rx;
    ev.smp   = smp;
    ev.drain = drain || ($urandom_range(0, 249) == 0);
    if (kind == KIND_SELECT) gen_selected = !sel;
    event_q.push_back(ev);
    event_total++;
  endtask

  // one register frame: select if needed, address, two data bytes, maybe cut short
  task automatic add_frame();
    logic [7:0] addr;
    logic [7:0] data;
    int         pick;
    int         cut;
    if (!gen_selected) add_event(KIND_SELECT, 1'b0, 8'($urandom), 10'($urandom));
    pick = $urandom_range(0, 9);
    if (pick < 3)       addr = ADDR_MASK_REG;
    else if (pick < 7)  addr = ADDR_SAMPLE_BASE + 8'($urandom_range(0, 7));
    else if (pick == 7) addr = ADDR_SAMPLE_END;
    else if (pick == 8) addr = 8'($urandom);
    else                addr = $urandom_range(0, 1) ? ADDR_TOP : ADDR_NONE;
    cut = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : 3;
    for (int i = 0; i < cut; i++) begin
      data = 8'($urandom);
      if (i == 0) begin
        data = addr;
      end else if (i == 1 && addr == ADDR_MASK_REG) begin
        // mostly busy masks, sometimes empty, full or one channel
        pick = $urandom_range(0, 7);
        if (pick == 0)      data = 8'h00;
        else if (pick == 1) data = 8'hFF;
        else if (pick == 2) data = 8'h01 << $urandom_range(0, 7);
      end
      add_event(KIND_BYTE, 1'($urandom), data, 10'($urandom));
      if ($urandom_range(0, 4) == 0)
        add_event(KIND_CONV_DONE, 1'($urandom), 8'($urandom), 10'($urandom));
    end
    if (cut < 3) add_event(KIND_SELECT, 1'($urandom), 8'($urandom), 10'($urandom));
    else if ($urandom_range(0, 3) == 0)
      add_event(KIND_SELECT, 1'b1, 8'($urandom), 10'($urandom));
  endtask

  task automatic build_stimulus();
    int pick;
    int start_total;
    // directed: idle paths, mask writes, sample reads, range edges, release mid-frame
    add_event(KIND_NONE,      1'b1, 8'hFF, 10'h3FF);
    add_event(KIND_BYTE,      1'b1, ADDR_MASK_REG, 10'h000);  // deselected, ignored
    add_event(KIND_CONV_DONE, 1'b0, 8'h00, 10'h2AA);          // idle, dropped
    add_event(KIND_SELECT,    1'b0, 8'h00, 10'h000);
    add_event(KIND_BYTE,      1'b0, ADDR_MASK_REG, 10'h000);
    add_event(KIND_BYTE,      1'b0, 8'hFF, 10'h000);          // all channels on
    add_event(KIND_BYTE,      1'b0, 8'h00, 10'h000);
    add_event(KIND_CONV_DONE, 1'b0, 8'h00, 10'h3FF);
    add_event(KIND_CONV_DONE, 1'b0, 8'h00, 10'h000);
    add_event(KIND_BYTE,      1'b0, ADDR_SAMPLE_BASE, 10'h000);
    add_event(KIND_BYTE,      1'b0, 8'h00, 10'h000);
    add_event(KIND_BYTE,      1'b0, 8'hAA, 10'h000);
    add_event(KIND_BYTE,      1'b0, ADDR_SAMPLE_END - 8'd1, 10'h000);
    add_event(KIND_SELECT,    1'b1, 8'h00, 10'h000);          // release keeps shift out
    add_event(KIND_BYTE,      1'b0, ADDR_SAMPLE_END, 10'h000);
    add_event(KIND_SELECT,    1'b0, 8'h00, 10'h000);
    add_event(KIND_BYTE,      1'b0, ADDR_SAMPLE_END, 10'h000);
    add_event(KIND_BYTE,      1'b0, 8'h55, 10'h000);
    add_event(KIND_BYTE,      1'b0, 8'h00, 10'h000);
    add_event(KIND_BYTE,      1'b0, ADDR_MASK_REG, 10'h000, 1'b1);
    add_event(KIND_BYTE,      1'b0, 8'h80, 10'h000);          // top channel only
    add_event(KIND_BYTE,      1'b0, ADDR_TOP, 10'h000);
    add_event(KIND_CONV_DONE, 1'b0, 8'h00, 10'h155);          // moves on to the top channel
    add_event(KIND_CONV_DONE, 1'b0, 8'h00, 10'h0F0);
    add_event(KIND_BYTE,      1'b0, ADDR_MASK_REG, 10'h000);
    add_event(KIND_BYTE,      1'b0, 8'h00, 10'h000);          // mask cleared
    add_event(KIND_BYTE,      1'b0, 8'h00, 10'h000);
    add_event(KIND_CONV_DONE, 1'b0, 8'h00, 10'h3FF);          // goes idle
    add_event(KIND_CONV_DONE, 1'b0, 8'h00, 10'h001);          // idle, dropped

    // random: mostly well-formed frames and conversions, some noise
    start_total = event_total;
    while (event_total - start_total < RANDOM_EVENTS) begin
      pick = $urandom_range(0, 99);
      if (pick < 45)
        add_frame();
      else if (pick < 75)
        add_event(KIND_CONV_DONE, 1'($urandom), 8'($urandom), 10'($urandom));
      else if (pick < 82)
        add_event(KIND_SELECT, 1'($urandom), 8'($urandom), 10'($urandom));
      else if (pick < 88)
        add_event(KIND_NONE, 1'($urandom), 8'($urandom), 10'($urandom));
      else if (pick < 95) begin
        if (!gen_selected) event_total--;  // ignored byte, not counted
        add_event(KIND_BYTE, 1'($urandom), 8'($urandom), 10'($urandom));
      end else
        add_event(KIND_SELECT, 1'b1, 8'($urandom), 10'($urandom));
    end
  endtask

  // ---------------------------------------------------------------------------
  // clock, reset and run control
  // ---------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    build_stimulus();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    // all stimulus on its way, then every result back, then a short tail
    do @(negedge clk_i); while (event_q.size() != 0 || s_axis_tvalid);
    do @(negedge clk_i); while (expected_out_q.size() != 0);
    repeat (TAIL_CYCLES) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("PASS spi_register_adc_scanner");
    end else begin
      $display("FAIL spi_register_adc_scanner");
    end
    $finish;
  end

  initial begin
    #(RUN_LIMIT);
    $display("timeout at %0t", $time);
    $display("FAIL spi_register_adc_scanner");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // driver: event beats from the queue with random gaps
  // ---------------------------------------------------------------------------
  int         send_gap   = 0;
  int         send_burst = 0;
  spi_event_t on_bus;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_scanner_response(on_bus);
        accepted_cnt++;
        send_gap = draw_gap(send_burst);
      end
      // bus free for a new beat unless the current one is still stalled
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (event_q.size() != 0 &&
                     (!event_q[0].drain || expected_out_q.size() == 0)) begin
          on_bus = event_q.pop_front();
          s_axis_tvalid <= 1'b1;
          // select_level, rx_byte, sample from bit 0 up
          s_axis_tdata  <= IN_TDATA_W'({on_bus.smp, on_bus.rx, on_bus.sel});
          s_axis_tuser  <= on_bus.kind;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: result beats against the oldest prediction, random stalls
  // ---------------------------------------------------------------------------
  int        stall_left  = 0;
  int        stall_burst = 0;
  scan_out_t want;

  task automatic check_field(input string name, input int exp_val, input int act_val);
    if (exp_val != act_val) begin
      fail_count++;
      $display("%0t mismatch %s: expected %0h actual %0h", $time, name, exp_val, act_val);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_out_q.size() == 0) begin
          fail_count++;
          $display("%0t unexpected result beat: expected none actual %h", $time,
                   m_axis_tdata);
        end else begin
          want = expected_out_q.pop_front();
          check_field("tx_byte",      want.tx,    m_axis_tdata[7:0]);
          check_field("start_conv",   want.start, m_axis_tdata[8]);
          check_field("conv_channel", want.chan,  m_axis_tdata[11:9]);
          check_field("attention",    want.attn,  m_axis_tdata[12]);
          check_field("pad",          0,          m_axis_tdata[15:13]);
        end
        stall_left = draw_gap(stall_burst);
      end
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

endmodule

### sim.f
hdl/spiadc_pkg.sv
hdl/spi_register_adc_scanner.sv
tb/spi_register_adc_scanner_tb.sv
